// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the frame receiver RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define S8_ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("frame receiver check failed");

// Antecedent implies consequent in the same cycle.
`define S8_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Antecedent implies consequent in the following cycle.
`define S8_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

// ----- rtl/s8fr_pkg.sv -----
// Package for the sum8 frame receiver: buffer sizing, frame constants,
// register indexes and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s8fr_pkg;

    // Frame buffer sizing
    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int FILL_W       = $clog2(BUFFER_BYTES + 1);

    // Frame layout constants
    localparam logic [FILL_W-1:0] MIN_FRAME  = FILL_W'(6);
    localparam logic [FILL_W-1:0] OVERHEAD   = FILL_W'(5);
    localparam logic [FILL_W-1:0] FULL_FILL  = FILL_W'(BUFFER_BYTES);
    localparam logic [ADDR_W-1:0] FIRST_DATA = ADDR_W'(3);

    // Register reset values
    localparam logic [7:0] HEAD_RESET = 8'hC5;
    localparam logic [7:0] TAIL_RESET = 8'h5C;

    // Register indexes on the configuration port
    typedef enum logic {
        REG_HEAD = 1'b0,
        REG_TAIL = 1'b1
    } reg_idx_t;

    // Framing bytes handed from the register file to the core
    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
    } frame_cfg_t;

    // One result record
    typedef struct packed {
        logic       status;
        logic [7:0] slave_address;
        logic [7:0] function_byte;
        logic [7:0] error_byte;
        logic [5:0] payload_length;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic [7:0] checksum_value;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/s8fr_regs.sv -----
// APB-style register file holding the head and tail framing bytes.
// Depends on s8fr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s8fr_regs
    import s8fr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output frame_cfg_t       cfg
);

    logic [7:0] head_reg;
    logic [7:0] tail_reg;
    reg_idx_t   idx;
    logic       wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_HEAD: head_reg <= pwdata[7:0];
                REG_TAIL: tail_reg <= pwdata[7:0];
                default:  ;
            endcase
        end
    end

    // Read decode
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_HEAD: prdata = {24'd0, head_reg};
            REG_TAIL: prdata = {24'd0, tail_reg};
            default:  prdata = '0;
        endcase
    end

    assign cfg.head_byte = head_reg;
    assign cfg.tail_byte = tail_reg;

endmodule

`default_nettype wire

// ----- rtl/s8fr_core.sv -----
// Frame buffer, byte collector and checksum/emit sequencer around one
// 8-bit checksum adder and one shared buffer read port. Depends on s8fr_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module s8fr_core
    import s8fr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  frame_cfg_t      cfg,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    input  wire logic       res_ready,
    output result_t         res
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SUM     = 6'b000010,
        ST_DRAIN   = 6'b000100,
        ST_CHECK   = 6'b001000,
        ST_EMIT_RD = 6'b010000,
        ST_EMIT_WR = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Frame buffer
    logic [7:0] mem [BUFFER_BYTES];
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;
    logic              rd_vld_reg;
    logic [ADDR_W-1:0] rd_tag_reg;

    // Collector and sequencer state
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] len_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] emit_idx_reg;
    logic [7:0]        sum_reg, chk_reg, addr_b_reg, func_reg, err_reg;
    logic              start_frame;
    logic              rx_take;

    logic [ADDR_W-1:0] last_idx;
    logic [FILL_W-1:0] plen;
    logic [FILL_W-1:0] emit_cnt;
    logic              emit_last;

    // Output register
    result_t out_reg;
    logic    out_vld_reg;
    logic    out_free;
    logic    load_fail;
    logic    load_emit;

    assign rx_ready  = (state_reg == ST_IDLE);
    assign rx_take   = rx_valid && rx_ready;
    assign last_idx  = ADDR_W'(len_reg - FILL_W'(2));
    assign plen      = len_reg - OVERHEAD;
    assign emit_cnt  = FILL_W'(emit_idx_reg) + FILL_W'(1);
    assign emit_last = (emit_cnt == plen);
    assign out_free  = !out_vld_reg || res_ready;
    assign load_fail = (state_reg == ST_CHECK) && (sum_reg != chk_reg) && out_free;
    assign load_emit = (state_reg == ST_EMIT_WR) && out_free;

    // Collect arriving bytes into the buffer
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = fill_reg[ADDR_W-1:0];
        fill_next   = fill_reg;
        start_frame = 1'b0;
        if (rx_take)
        begin
            if (fill_reg == '0)
            begin
                if (rx_byte == cfg.head_byte)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    fill_next = FILL_W'(1);
                end
            end
            else if (fill_reg >= FULL_FILL)
            begin
                fill_next = '0;
            end
            else if (rx_byte == cfg.head_byte)
            begin
                wr_en = 1'b1;
                if (fill_reg < MIN_FRAME)
                begin
                    // Restart on a head seen early in the frame
                    wr_addr   = '0;
                    fill_next = FILL_W'(1);
                end
                else
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            else
            begin
                wr_en     = 1'b1;
                fill_next = fill_reg + FILL_W'(1);
                if (rx_byte == cfg.tail_byte)
                begin
                    fill_next   = '0;
                    start_frame = (fill_reg + FILL_W'(1) >= MIN_FRAME);
                end
            end
        end
    end

    // Select the buffer read address
    always_comb
    begin
        rd_en   = (state_reg == ST_SUM) || (state_reg == ST_EMIT_RD);
        rd_addr = (state_reg == ST_SUM) ? ptr_reg : (emit_idx_reg + FIRST_DATA);
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start_frame)
                    state_next = ST_SUM;
            ST_SUM:
                if (ptr_reg == last_idx)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                state_next = ST_CHECK;
            ST_CHECK:
                if (sum_reg == chk_reg)
                    state_next = ST_EMIT_RD;
                else if (out_free)
                    state_next = ST_IDLE;
            ST_EMIT_RD:
                state_next = ST_EMIT_WR;
            ST_EMIT_WR:
                if (out_free)
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            rd_vld_reg <= (state_reg == ST_SUM);
            if (load_fail || load_emit)
                out_vld_reg <= 1'b1;
            else if (res_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= rx_byte;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_tag_reg  <= rd_addr;
        end
    end

    // Checksum pass through the 8-bit checksum adder, then emit pointer
    always_ff @(posedge clk)
    begin
        if (start_frame)
        begin
            len_reg <= fill_reg + FILL_W'(1);
            ptr_reg <= '0;
            sum_reg <= '0;
        end
        if (state_reg == ST_SUM)
            ptr_reg <= ptr_reg + ADDR_W'(1);
        if (rd_vld_reg)
        begin
            if (rd_tag_reg == last_idx)
                chk_reg <= rd_data_reg;
            else
                sum_reg <= sum_reg + rd_data_reg;
            if (rd_tag_reg == ADDR_W'(1))
                addr_b_reg <= rd_data_reg;
            if (rd_tag_reg == ADDR_W'(2))
                func_reg <= rd_data_reg;
            if (rd_tag_reg == FIRST_DATA)
                err_reg <= rd_data_reg;
        end
        if (state_reg == ST_CHECK)
            emit_idx_reg <= '0;
        else if (load_emit)
            emit_idx_reg <= emit_idx_reg + ADDR_W'(1);
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (load_fail)
        begin
            out_reg.status         <= 1'b1;
            out_reg.slave_address  <= '0;
            out_reg.function_byte  <= '0;
            out_reg.error_byte     <= '0;
            out_reg.payload_length <= '0;
            out_reg.byte_index     <= '0;
            out_reg.payload_byte   <= '0;
            out_reg.checksum_value <= '0;
            out_reg.last           <= 1'b0;
        end
        else if (load_emit)
        begin
            out_reg.status         <= 1'b0;
            out_reg.slave_address  <= addr_b_reg;
            out_reg.function_byte  <= func_reg;
            out_reg.error_byte     <= err_reg;
            out_reg.payload_length <= 6'(plen);
            out_reg.byte_index     <= 6'(emit_idx_reg);
            out_reg.payload_byte   <= rd_data_reg;
            out_reg.checksum_value <= chk_reg;
            out_reg.last           <= emit_last;
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = out_reg;

    // The collector is idle while a frame is being checked or emitted
    `S8_ASSERT_IMPL(a_fill_clear, clk, rst_n, state_reg != ST_IDLE, fill_reg == '0)
    // A failure result never marks the end of a run
    `S8_ASSERT_IMPL(a_fail_not_last, clk, rst_n, out_vld_reg && out_reg.status, !out_reg.last)
    // Emit pointer stays inside the payload
    `S8_ASSERT_IMPL(a_emit_range, clk, rst_n, state_reg == ST_EMIT_WR, emit_cnt <= plen)
    // Checksum pass never reads past the checksum byte
    `S8_ASSERT_IMPL(a_sum_range, clk, rst_n, state_reg == ST_SUM, ptr_reg <= last_idx)

endmodule

`default_nettype wire

// ----- rtl/sum8_frame_receiver.sv -----
// sum8_frame_receiver: receive channel of the head/tail sum8 framing.
// Channels: rx_valid/rx_ready carry one received byte (rx_byte) per transfer;
// out_valid/out_ready carry one result per transfer; an APB-style port
// writes head_byte (address 0) and tail_byte (address 4).
// Sequence: a tail byte closing a frame of len bytes starts a checksum pass
// that reads the buffer once per cycle through one read port and one 8-bit
// adder: len - 1 reads, a drain state and a compare state. A good frame then
// emits len - 5 results, each through a buffer read state and then an output
// load state; a mismatch emits one failure result. rx_ready stays low from
// the closing tail byte until the final result sits in the output register.
// Stalls: out_ready low holds the output register and the sequencer waits
// in place; rx_ready returns once the last result is loaded, so the next
// byte is taken while that result still waits.
// Reset: head 0xC5, tail 0x5C, collector waiting for head, no result
// pending. The frame buffer is not cleared; only entries written in the
// current frame are ever read.
// Depends on s8fr_pkg, s8fr_regs and s8fr_core.
`timescale 1ns / 1ps
`default_nettype none

module sum8_frame_receiver
    import s8fr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        rx_valid,
    output logic             rx_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic      [7:0]  slave_address,
    output logic      [7:0]  function_byte,
    output logic      [7:0]  error_byte,
    output logic      [5:0]  payload_length,
    output logic      [5:0]  byte_index,
    output logic      [7:0]  payload_byte,
    output logic      [7:0]  checksum_value,
    output logic             last
);

    frame_cfg_t cfg;
    result_t    res;

    // Configuration registers
    s8fr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Collector, checksum pass and emit sequencer
    s8fr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    // Unpack the result record onto the ports
    assign status         = res.status;
    assign slave_address  = res.slave_address;
    assign function_byte  = res.function_byte;
    assign error_byte     = res.error_byte;
    assign payload_length = res.payload_length;
    assign byte_index     = res.byte_index;
    assign payload_byte   = res.payload_byte;
    assign checksum_value = res.checksum_value;
    assign last           = res.last;

endmodule

`default_nettype wire
